[hw/rtl/sqa_pkg.sv]
// ----------------------------------------------------------------------------
// sqa_pkg
// Shared types, constants and helpers for the shared queue id allocator.
// ----------------------------------------------------------------------------
package sqa_pkg;

   localparam int UNITS  = 4;
   localparam int PORTS  = 32;
   localparam int QUEUES = 32;

   // ids beyond 32 cannot be named by the 5-bit result
   localparam int QLIM  = (QUEUES < 32) ? QUEUES : 32;
   localparam int ROWS  = UNITS * QUEUES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [31:0] PORT_RANGE =
      (PORTS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PORTS) - 32'd1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [1:0] CSR_QUEUES_IN_USE = 2'd0;
   localparam logic [1:0] CSR_PORTS_PRESENT = 2'd1;
   localparam logic [1:0] CSR_UNITS_PRESENT = 2'd2;

   typedef struct packed {
      logic load;
      logic issue;
      logic fread;
      logic alloc_commit;
      logic free_commit;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic op_free;
      logic scan_done;
      logic out_free;
   } sts_type;

   function automatic logic [ROW_W-1:0] row_addr(input logic [1:0] unit,
                                                 input logic [4:0] q);
      logic [ROW_W+7:0] a;
      a = (ROW_W+8)'(unit) * (ROW_W+8)'(QUEUES) + (ROW_W+8)'(q);
      return a[ROW_W-1:0];
   endfunction

endpackage

[hw/rtl/shared_queue_id_allocator.sv]
// ----------------------------------------------------------------------------
// shared_queue_id_allocator
// Best-fit queue id allocator over a per unit, per queue, per port used table.
// ----------------------------------------------------------------------------
// One request at a time. An allocate reads the unit's rows for each usable queue
// id, one queue id per cycle through the single read port of the used table,
// then commits; a free reads the addressed row and then commits, and a rejected
// request goes from the check straight to the response. A
// finished response waits in an output register. Each table row has a valid
// bit cleared by reset, so no clearing pass follows reset. Configuration
// writes are always ready and take effect on the next cycle.
module shared_queue_id_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [1:0]  req_unit,
   input  logic [31:0] req_port_mask,
   input  logic [4:0]  req_queue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_granted_queue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import sqa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sqa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_unit          (req_unit),
      .req_port_mask     (req_port_mask),
      .req_queue         (req_queue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_queue (rsp_granted_queue),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

[hw/rtl/sqa_ctrl.sv]
// ----------------------------------------------------------------------------
// sqa_ctrl
// Sequencer for the allocator: precheck, queue scan, commit and response.
// ----------------------------------------------------------------------------
module sqa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sqa_pkg::sts_type sts,
   output sqa_pkg::cmd_type cmd
);
   import sqa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_ALLOC = 3'd3;
   localparam logic [2:0] S_FREAD = 3'd4;
   localparam logic [2:0] S_FCHK  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.bad)
               state_in = S_RESP;
            else if (sts.op_free)
               state_in = S_FREAD;
            else
               state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_done)
               state_in = S_ALLOC;
            else
               cmd.issue = 1'b1;
         end
         S_ALLOC: begin
            cmd.alloc_commit = 1'b1;
            state_in         = S_RESP;
         end
         S_FREAD: begin
            cmd.fread = 1'b1;
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            cmd.free_commit = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

[hw/rtl/sqa_datapath.sv]
// ----------------------------------------------------------------------------
// sqa_datapath
// Used-bit table, configuration registers, best-fit scan and result register.
// ----------------------------------------------------------------------------
module sqa_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_op,
   input  logic [1:0]       req_unit,
   input  logic [31:0]      req_port_mask,
   input  logic [4:0]       req_queue,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_granted_queue,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data,
   input  sqa_pkg::cmd_type cmd,
   output sqa_pkg::sts_type sts
);
   import sqa_pkg::*;

   function automatic logic [5:0] popcount(input logic [31:0] v);
      logic [5:0] c;
      c = '0;
      for (int i = 0; i < 32; i++)
         c = c + 6'(v[i]);
      return c;
   endfunction

   // configuration
   logic [5:0]  queues_in_use_ff;
   logic [31:0] ports_present_ff;
   logic [3:0]  units_present_ff;

   // request
   logic        op_ff, op_in;
   logic [1:0]  unit_ff, unit_in;
   logic [31:0] mask_ff, mask_in;
   logic [4:0]  queue_ff, queue_in;
   logic        bad_ff, bad_in;

   // scan
   logic [5:0]  cnt_ff, cnt_in;
   logic        evl_ff, evl_in;
   logic [4:0]  evq_ff, evq_in;
   logic        found_ff, found_in;
   logic [4:0]  best_ff, best_in;
   logic [5:0]  bestf_ff, bestf_in;
   logic [31:0] brow_ff, brow_in;

   // result
   logic [1:0]  res_status_ff, res_status_in;
   logic [4:0]  res_queue_ff, res_queue_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [4:0]  out_queue_ff, out_queue_in;

   // table
   logic [31:0]      mem [ROWS];
   logic [ROWS-1:0]  vld_ff;
   logic [31:0]      rd_data_ff;
   logic             rd_vld_ff;
   logic [ROW_W-1:0] rd_addr, wr_addr;
   logic [31:0]      wr_data;
   logic             wr_en;

   logic [31:0] present, row_rd;
   logic [5:0]  n_usable, fac;
   logic        take, free_ok, req_bad;

   assign csr_ready = 1'b1;
   assign present   = ports_present_ff & PORT_RANGE;
   assign n_usable  = (queues_in_use_ff > 6'(QLIM)) ? 6'(QLIM) : queues_in_use_ff;

   always_comb begin
      req_bad = 1'b0;
      if (int'(req_unit) >= UNITS || !units_present_ff[req_unit])
         req_bad = 1'b1;
      if (req_port_mask == '0 || (req_port_mask & ~present) != '0)
         req_bad = 1'b1;
      if (req_op == OP_FREE && {1'b0, req_queue} >= n_usable)
         req_bad = 1'b1;
   end

   assign row_rd  = rd_vld_ff ? rd_data_ff : '0;
   assign fac     = popcount(row_rd & present);
   assign take    = evl_ff && ((row_rd & mask_ff) == '0) &&
                    (!found_ff || fac > bestf_ff);
   assign free_ok = ((row_rd & mask_ff) == mask_ff);

   assign rd_addr = cmd.issue ? row_addr(unit_ff, cnt_ff[4:0])
                              : row_addr(unit_ff, queue_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = row_addr(unit_ff, queue_ff);
      wr_data = row_rd & ~mask_ff;
      if (cmd.alloc_commit) begin
         wr_en   = found_ff;
         wr_addr = row_addr(unit_ff, best_ff);
         wr_data = brow_ff | mask_ff;
      end else if (cmd.free_commit) begin
         wr_en = free_ok;
      end
   end

   always_comb begin
      op_in         = op_ff;
      unit_in       = unit_ff;
      mask_in       = mask_ff;
      queue_in      = queue_ff;
      bad_in        = bad_ff;
      cnt_in        = cnt_ff;
      evl_in        = cmd.issue;
      evq_in        = cnt_ff[4:0];
      found_in      = found_ff;
      best_in       = best_ff;
      bestf_in      = bestf_ff;
      brow_in       = brow_ff;
      res_status_in = res_status_ff;
      res_queue_in  = res_queue_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_queue_in  = out_queue_ff;

      if (cmd.load) begin
         op_in         = req_op;
         unit_in       = req_unit;
         mask_in       = req_port_mask;
         queue_in      = req_queue;
         bad_in        = req_bad;
         cnt_in        = '0;
         found_in      = 1'b0;
         res_status_in = ST_BAD;
         res_queue_in  = '0;
      end
      if (cmd.issue)
         cnt_in = cnt_ff + 6'd1;
      if (take) begin
         found_in = 1'b1;
         best_in  = evq_ff;
         bestf_in = fac;
         brow_in  = row_rd;
      end
      if (cmd.alloc_commit) begin
         res_status_in = found_ff ? ST_OK : ST_FULL;
         res_queue_in  = found_ff ? best_ff : 5'd0;
      end
      if (cmd.free_commit)
         res_status_in = free_ok ? ST_OK : ST_BAD;
      if (cmd.respond) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_queue_in  = res_queue_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queues_in_use_ff <= 6'd32;
         ports_present_ff <= 32'hFFFF_FFFF;
         units_present_ff <= 4'hF;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_QUEUES_IN_USE: queues_in_use_ff <= csr_data[5:0];
            CSR_PORTS_PRESENT: ports_present_ff <= csr_data;
            CSR_UNITS_PRESENT: units_present_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evl_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         evl_ff       <= evl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      unit_ff       <= unit_in;
      mask_ff       <= mask_in;
      queue_ff      <= queue_in;
      bad_ff        <= bad_in;
      cnt_ff        <= cnt_in;
      evq_ff        <= evq_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      bestf_ff      <= bestf_in;
      brow_ff       <= brow_in;
      res_status_ff <= res_status_in;
      res_queue_ff  <= res_queue_in;
      out_status_ff <= out_status_in;
      out_queue_ff  <= out_queue_in;
   end

   // row valid bits: a row never written reads as all free
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (wr_en)
         vld_ff[wr_addr] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign sts.bad       = bad_ff;
   assign sts.op_free   = (op_ff == OP_FREE);
   assign sts.scan_done = (cnt_ff >= n_usable);
   assign sts.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_granted_queue = out_queue_ff;

`ifndef SYNTHESIS
   a_respond_free: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> (!out_valid_ff || !rsp_stall))
      else $error("response loaded over a pending one");

   a_queue_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != ST_OK) |-> (out_queue_ff == '0))
      else $error("granted queue set on failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_status_ff == ST_OK || out_status_ff == ST_FULL ||
                        out_status_ff == ST_BAD))
      else $error("undefined status code");

   a_eval_follows_issue: assert property (@(posedge clock) disable iff (reset)
      evl_ff |-> $past(cmd.issue))
      else $error("scan evaluation without a read");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared queue id allocator.
// ----------------------------------------------------------------------------
// A driver presents queued allocate and free requests. A monitor predicts each
// accepted request against a local copy of the used table and registers, then
// checks every response in order. Register settings change between phases while
// the block is idle. Both sides insert random idle cycles, except in the last phases.
// ----------------------------------------------------------------------------
module tb_top;
   import sqa_pkg::*;

   localparam int            WATCHDOG_LIMIT = 3000;
   localparam int            DRAIN_CYCLES   = QLIM + 8;
   localparam logic [1:0]    CSR_SPARE      = 2'd3;

   typedef struct packed {
      logic        op;
      logic [1:0]  unit;
      logic [31:0] port_mask;
      logic [4:0]  queue;
      bit          pick_live;
      bit          wait_drain;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] granted_queue;
   } alloc_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [1:0]  req_unit;
   logic [31:0] req_port_mask;
   logic [4:0]  req_queue;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_granted_queue;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   // local copy of the used table and registers
   logic [31:0] used_rows [ROWS];
   logic [5:0]  cfg_queues;
   logic [31:0] cfg_ports;
   logic [3:0]  cfg_units;

   alloc_req_type pending [$];
   alloc_rsp_type predicted [$];

   bit req_taken;
   int send_idle_pct;
   int recv_idle_pct;
   int n_errors;
   int n_reqs;
   int n_ok;
   int n_full;
   int n_bad;
   int n_csr_writes;
   int idle_cycles;

   shared_queue_id_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_unit          (req_unit),
      .req_port_mask     (req_port_mask),
      .req_queue         (req_queue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_queue (rsp_granted_queue),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int usable_ids();
      int n;
      n = int'(cfg_queues);
      if (n > QLIM) n = QLIM;
      return n;
   endfunction

   function automatic logic [1:0] pick_unit();
      int u;
      if (cfg_units == 0) return 2'($urandom_range(UNITS-1));
      do u = $urandom_range(UNITS-1); while (!cfg_units[u]);
      return u[1:0];
   endfunction

   function automatic logic [31:0] pick_ports();
      logic [31:0] live;
      logic [31:0] m;
      int          b;
      live = cfg_ports & PORT_RANGE;
      if (live == 0) return $urandom;
      case ($urandom_range(3))
         0: m = '0;
         1: m = live & $urandom & $urandom;
         2: m = live & $urandom;
         default: m = live;
      endcase
      if (m == 0) begin
         do b = $urandom_range(PORTS-1); while (!live[b]);
         m[b] = 1'b1;
      end
      return m;
   endfunction

   function automatic alloc_req_type gen_random_req();
      alloc_req_type r;
      int            kind;
      kind = $urandom_range(99);
      r.op = OP_ALLOC;
      r.unit = pick_unit();
      r.port_mask = pick_ports();
      r.queue = 5'($urandom_range(31));
      r.pick_live = 1'b0;
      r.wait_drain = ($urandom_range(59) == 0);
      if (kind >= 50 && kind < 85) begin
         r.op = OP_FREE;
         r.pick_live = 1'b1;
      end else if (kind >= 85) begin
         r.op = 1'($urandom_range(1));
         r.unit = 2'($urandom_range(3));
         case ($urandom_range(2))
            0: r.port_mask = $urandom;
            1: r.port_mask = '0;
            default: r.port_mask = r.port_mask | (32'd1 << $urandom_range(31));
         endcase
      end
      return r;
   endfunction

   // free aimed at a queue id that is currently held
   task automatic resolve_free(inout alloc_req_type r);
      logic [31:0] live;
      logic [31:0] m;
      int          cands [$];
      int          pick;
      int          u;
      u = int'(pick_unit());
      for (int q = 0; q < usable_ids(); q++) begin
         if ((used_rows[u*QUEUES+q] & cfg_ports) != 0) cands.push_back(q);
      end
      r.unit = u[1:0];
      if (cands.size() == 0) return;
      pick = cands[$urandom_range(cands.size()-1)];
      live = used_rows[u*QUEUES+pick] & cfg_ports;
      case ($urandom_range(9))
         0, 1, 2: m = live;
         3: m = live | pick_ports();
         default: begin
            m = live & $urandom;
            if (m == 0) m = live & (~live + 32'd1);
         end
      endcase
      r.queue = pick[4:0];
      r.port_mask = m;
   endtask

   task automatic compute_grant(input logic op, input logic [1:0] unit,
                                input logic [31:0] mask, input logic [4:0] queue,
                                output alloc_rsp_type rsp);
      logic [31:0] live;
      logic [31:0] row;
      int          n;
      int          best;
      int          best_cnt;
      int          cnt;
      int          idx;
      bit          found;
      live = cfg_ports & PORT_RANGE;
      n = usable_ids();
      rsp.status = ST_BAD;
      rsp.granted_queue = '0;
      if (unit >= UNITS || !cfg_units[unit]) return;
      if (mask == 0 || (mask & ~live) != 0) return;
      if (op == OP_ALLOC) begin
         found = 1'b0;
         best = 0;
         best_cnt = 0;
         for (int q = 0; q < n; q++) begin
            row = used_rows[unit*QUEUES+q];
            if ((row & mask) == 0) begin
               cnt = $countones(row & live);
               if (!found || cnt > best_cnt) begin
                  found = 1'b1;
                  best = q;
                  best_cnt = cnt;
               end
            end
         end
         if (!found) begin
            rsp.status = ST_FULL;
            return;
         end
         used_rows[unit*QUEUES+best] |= mask;
         rsp.status = ST_OK;
         rsp.granted_queue = best[4:0];
      end else begin
         idx = int'(unit)*QUEUES + int'(queue);
         if (queue >= n || (used_rows[idx] & mask) != mask) return;
         used_rows[idx] &= ~mask;
         rsp.status = ST_OK;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
      n_errors++;
      $display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, got_v, $time);
   endtask

   task automatic push_req(input logic op, input logic [1:0] unit, input logic [31:0] mask,
                           input logic [4:0] queue, input bit drain);
      alloc_req_type r;
      r.op = op;
      r.unit = unit;
      r.port_mask = mask;
      r.queue = queue;
      r.pick_live = 1'b0;
      r.wait_drain = drain;
      pending.push_back(r);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_QUEUES_IN_USE: cfg_queues = data[5:0];
         CSR_PORTS_PRESENT: cfg_ports  = data;
         CSR_UNITS_PRESENT: cfg_units  = data[3:0];
         default: ;
      endcase
      n_csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pending.size() != 0 || req_valid || predicted.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_block(input logic [5:0] nq, input logic [31:0] ports,
                            input logic [3:0] units, input int count);
      write_csr(CSR_QUEUES_IN_USE, {26'd0, nq});
      write_csr(CSR_PORTS_PRESENT, ports);
      write_csr(CSR_UNITS_PRESENT, {28'd0, units});
      for (int i = 0; i < count; i++) pending.push_back(gen_random_req());
      wait_idle();
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      alloc_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending.size() != 0 && !(pending[0].wait_drain && predicted.size() != 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt = pending.pop_front();
            if (nxt.pick_live) resolve_free(nxt);
            req_valid     <= 1'b1;
            req_op        <= nxt.op;
            req_unit      <= nxt.unit;
            req_port_mask <= nxt.port_mask;
            req_queue     <= nxt.queue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_stall
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      alloc_rsp_type want;
      bit            moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (predicted.size() == 0) begin
               report_mismatch("response with no request outstanding", 32'd0,
                               32'(rsp_status));
            end else begin
               want = predicted.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_granted_queue !== want.granted_queue)
                  report_mismatch("granted_queue", 32'(want.granted_queue),
                                  32'(rsp_granted_queue));
               case (want.status)
                  ST_OK:   n_ok++;
                  ST_FULL: n_full++;
                  default: n_bad++;
               endcase
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            compute_grant(req_op, req_unit, req_port_mask, req_queue, want);
            predicted.push_back(want);
            req_taken = 1'b1;
            n_reqs++;
         end
         if (csr_valid && csr_ready) moved = 1'b1;
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = 1'b0;
      req_unit      = '0;
      req_port_mask = '0;
      req_queue     = '0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      cfg_queues    = 6'd32;
      cfg_ports     = 32'hFFFF_FFFF;
      cfg_units     = 4'hF;
      req_taken     = 1'b0;
      send_idle_pct = 22;
      recv_idle_pct = 55;
      n_errors      = 0;
      n_reqs        = 0;
      n_ok          = 0;
      n_full        = 0;
      n_bad         = 0;
      n_csr_writes  = 0;
      idle_cycles   = 0;
      for (int i = 0; i < ROWS; i++) used_rows[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: best fit, ties, full masks, bad masks and clear-bit frees
      push_req(OP_ALLOC, 2'd0, 32'h0000_0001, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd0, 32'h0000_0001, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd0, 32'hFFFF_FFFF, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd0, 32'h0000_0002, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd0, 32'h0000_0004, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd3, 32'h8000_0000, 5'd31, 1'b0);
      push_req(OP_ALLOC, 2'd1, 32'h0000_0000, 5'd0, 1'b0);
      push_req(OP_FREE,  2'd0, 32'hFFFF_FFFF, 5'd2, 1'b0);
      push_req(OP_FREE,  2'd0, 32'h0000_0001, 5'd2, 1'b0);
      push_req(OP_FREE,  2'd0, 32'h0000_0001, 5'd31, 1'b0);
      push_req(OP_FREE,  2'd1, 32'h0000_0004, 5'd0, 1'b0);
      push_req(OP_FREE,  2'd2, 32'h0000_0000, 5'd5, 1'b0);
      push_req(OP_ALLOC, 2'd2, 32'hAAAA_AAAA, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd2, 32'h5555_5555, 5'd0, 1'b0);
      push_req(OP_ALLOC, 2'd2, 32'hFFFF_FFFF, 5'd0, 1'b0);
      push_req(OP_FREE,  2'd0, 32'h0000_0007, 5'd0, 1'b1);
      push_req(OP_FREE,  2'd3, 32'h8000_0000, 5'd0, 1'b0);
      push_req(OP_FREE,  2'd2, 32'hFFFF_FFFF, 5'd0, 1'b0);
      push_req(OP_FREE,  2'd2, 32'h0000_0001, 5'd1, 1'b0);
      push_req(OP_ALLOC, 2'd1, 32'hFFFF_FFFF, 5'd0, 1'b0);
      wait_idle();

      run_block(6'd32, 32'hFFFF_FFFF, 4'hF, 140);
      run_block(6'd4,  32'h0000_00FF, 4'h5, 140);

      send_idle_pct = 55;
      recv_idle_pct = 22;
      run_block(6'd1,  32'hFFFF_FFFF, 4'hF, 120);
      run_block(6'd63, 32'h8000_0001, 4'hA, 140);
      run_block(6'd0,  32'hFFFF_FFFF, 4'hF, 40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_SPARE, $urandom);
      run_block(6'($urandom_range(2, 8)), $urandom | 32'd1, 4'($urandom_range(1, 15)), 140);
      run_block(6'd32, 32'h0000_0000, 4'h0, 20);
      run_block(6'd8,  32'hFFFF_FFFF, 4'hF, 100);

      $display("run covered %0d requests: %0d ok, %0d no free id, %0d rejected",
               n_reqs, n_ok, n_full, n_bad);
      $display("across %0d register writes, %0d mismatches", n_csr_writes, n_errors);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/sqa_pkg.sv
hw/rtl/sqa_ctrl.sv
hw/rtl/sqa_datapath.sv
hw/rtl/shared_queue_id_allocator.sv
test/tb_top.sv
